>>> rtl/core/qcts_pkg.sv
// shared constants and types for the quad corner track stabilizer
`default_nettype none

package qcts_pkg;

  // default structural parameters
  localparam int DEF_WINDOW_LEN = 5;
  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_FRAC_BITS  = 8;

  // ema weight: q8 fraction, one is 256
  localparam int ALPHA_BITS  = 9;
  localparam int ALPHA_SHIFT = 8;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 9'd256;

  localparam int THRESH_BITS = 3;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = ALPHA_BITS;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESH = 1'd1;

  // corner slots, in output order
  typedef enum logic [1:0] {
    QUAD_TL = 2'd0,
    QUAD_TR = 2'd1,
    QUAD_BR = 2'd2,
    QUAD_BL = 2'd3
  } quad_t;

  localparam int NUM_CORNERS = 4;

endpackage

`default_nettype wire

>>> rtl/core/qcts_quad_sort.sv
// sorts four raw corners into quadrant slots around their centroid
`default_nettype none

module qcts_quad_sort
  import qcts_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic [COORD_BITS-1:0] raw_x  [NUM_CORNERS],
  input  logic [COORD_BITS-1:0] raw_y  [NUM_CORNERS],
  output logic [COORD_BITS-1:0] slot_x [NUM_CORNERS],
  output logic [COORD_BITS-1:0] slot_y [NUM_CORNERS]
);

  localparam int SUM_BITS = COORD_BITS + 2;

  logic [SUM_BITS-1:0] sum_x;
  logic [SUM_BITS-1:0] sum_y;

  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      sum_x = sum_x + SUM_BITS'(raw_x[i]);
      sum_y = sum_y + SUM_BITS'(raw_y[i]);
    end
  end

  // later points overwrite earlier ones in the same slot; empty slots stay zero
  always_comb begin
    logic [SUM_BITS-1:0] x4;
    logic [SUM_BITS-1:0] y4;
    quad_t               q;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      slot_x[k] = '0;
      slot_y[k] = '0;
    end
    for (int i = 0; i < NUM_CORNERS; i++) begin
      x4 = {raw_x[i], 2'b00};
      y4 = {raw_y[i], 2'b00};
      priority if (x4 < sum_x && y4 < sum_y) begin
        q = QUAD_TL;
      end else if (x4 > sum_x && y4 < sum_y) begin
        q = QUAD_TR;
      end else if (x4 > sum_x && y4 > sum_y) begin
        q = QUAD_BR;
      end else begin
        q = QUAD_BL;
      end
      slot_x[q] = raw_x[i];
      slot_y[q] = raw_y[i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/qcts_ema_lane.sv
// one coordinate of the ema: blend of new and held value, truncated
`default_nettype none

module qcts_ema_lane
  import qcts_pkg::*;
#(
  parameter int FIX_BITS = DEF_COORD_BITS + DEF_FRAC_BITS
) (
  input  logic [ALPHA_BITS-1:0] alpha,
  input  logic                  first,
  input  logic [FIX_BITS-1:0]   new_val,
  input  logic [FIX_BITS-1:0]   held_val,
  output logic [FIX_BITS-1:0]   blend_val
);

  localparam int PROD_BITS = FIX_BITS + ALPHA_BITS;

  logic [ALPHA_BITS-1:0] beta;
  logic [PROD_BITS-1:0]  prod_new;
  logic [PROD_BITS-1:0]  prod_held;
  logic [PROD_BITS:0]    acc;

  assign beta      = ALPHA_ONE - alpha;
  assign prod_new  = PROD_BITS'(alpha) * PROD_BITS'(new_val);
  assign prod_held = PROD_BITS'(beta) * PROD_BITS'(held_val);
  assign acc       = (PROD_BITS + 1)'(prod_new) + (PROD_BITS + 1)'(prod_held);

  // first hit loads the corner directly
  assign blend_val = first ? new_val : acc[ALPHA_SHIFT +: FIX_BITS];

endmodule

`default_nettype wire

>>> rtl/core/qcts_window.sv
// sliding window of detection flags with a running hit count
`default_nettype none

module qcts_window
  import qcts_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   hit,
  input  logic                   update,
  input  logic [THRESH_BITS-1:0] threshold,
  output logic                   stable
);

  localparam int CNT_BITS = $clog2(WINDOW_LEN + 1);
  localparam int CMP_BITS = (CNT_BITS > THRESH_BITS) ? CNT_BITS : THRESH_BITS;

  logic [WINDOW_LEN-1:0] hist;
  logic [WINDOW_LEN-1:0] hist_next;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;

  // newest flag enters at bit 0, the oldest drops off the top
  assign hist_next  = WINDOW_LEN'({hist, hit});
  assign count_next = count + CNT_BITS'(hit) - CNT_BITS'(hist[WINDOW_LEN-1]);
  assign stable     = CMP_BITS'(count_next) >= CMP_BITS'(threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist  <= '0;
      count <= '0;
    end else if (update) begin
      hist  <= hist_next;
      count <= count_next;
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    int'(count) == $countones(hist))
    else $error("hit count out of step with window");

endmodule

`default_nettype wire

>>> rtl/core/quad_corner_track_stabilizer.sv
// top level: input register, quadrant sort, ema and window, result register
`default_nettype none

// Takes one frame per transfer: a detect flag and four unordered corners. The
// corners are sorted into top-left/top-right/bottom-right/bottom-left order
// around their centroid, smoothed by a per-coordinate EMA (weight alpha_q8/256,
// values above 256 act as 256) in unsigned fixed point with FRAC_BITS fraction
// bits, and reported with their mean as center. A frame without detection
// holds the last smoothed corners while at least pass_threshold of the last
// WINDOW_LEN frames were hits, otherwise it reports lost with all fields zero.
// One frame is accepted every cycle unless a full result register is stalled by
// out_ready; a frame is held in the input register, where sort, EMA and window
// update are done, and then moves into the result register. The EMA and window
// state advance as each frame moves into the result register. Configuration must
// be written only while no frame is in flight; the block does not enforce this.
module quad_corner_track_stabilizer
  import qcts_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  localparam int FIX_BITS  = COORD_BITS + FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      detect_ok,
  input  logic [COORD_BITS-1:0]     pt0_x,
  input  logic [COORD_BITS-1:0]     pt0_y,
  input  logic [COORD_BITS-1:0]     pt1_x,
  input  logic [COORD_BITS-1:0]     pt1_y,
  input  logic [COORD_BITS-1:0]     pt2_x,
  input  logic [COORD_BITS-1:0]     pt2_y,
  input  logic [COORD_BITS-1:0]     pt3_x,
  input  logic [COORD_BITS-1:0]     pt3_y,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      track_status,
  output logic [FIX_BITS-1:0]       top_left_x,
  output logic [FIX_BITS-1:0]       top_left_y,
  output logic [FIX_BITS-1:0]       top_right_x,
  output logic [FIX_BITS-1:0]       top_right_y,
  output logic [FIX_BITS-1:0]       bottom_right_x,
  output logic [FIX_BITS-1:0]       bottom_right_y,
  output logic [FIX_BITS-1:0]       bottom_left_x,
  output logic [FIX_BITS-1:0]       bottom_left_y,
  output logic [FIX_BITS-1:0]       center_x,
  output logic [FIX_BITS-1:0]       center_y
);

  localparam int NUM_COORDS = 2 * NUM_CORNERS;
  localparam int CSUM_BITS  = FIX_BITS + 2;

  // configuration
  logic [ALPHA_BITS-1:0]  alpha_q8;
  logic [THRESH_BITS-1:0] pass_threshold;
  logic [ALPHA_BITS-1:0]  alpha_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q8       <= ALPHA_BITS'(102);
      pass_threshold <= THRESH_BITS'(3);
    end else if (cfg_we) begin
      if (cfg_index == REG_ALPHA) begin
        alpha_q8 <= cfg_data;
      end else if (cfg_index == REG_THRESH) begin
        pass_threshold <= cfg_data[THRESH_BITS-1:0];
      end
    end
  end

  assign alpha_sat = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;

  // input register
  logic                  s1_valid;
  logic                  s1_detect;
  logic [COORD_BITS-1:0] s1_x [NUM_CORNERS];
  logic [COORD_BITS-1:0] s1_y [NUM_CORNERS];
  logic                  advance;
  logic                  move;

  assign advance  = !out_valid || out_ready;
  assign move     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_detect <= detect_ok;
      s1_x[0]   <= pt0_x;
      s1_y[0]   <= pt0_y;
      s1_x[1]   <= pt1_x;
      s1_y[1]   <= pt1_y;
      s1_x[2]   <= pt2_x;
      s1_y[2]   <= pt2_y;
      s1_x[3]   <= pt3_x;
      s1_y[3]   <= pt3_y;
    end
  end

  // quadrant sort
  logic [COORD_BITS-1:0] slot_x [NUM_CORNERS];
  logic [COORD_BITS-1:0] slot_y [NUM_CORNERS];

  qcts_quad_sort #(
    .COORD_BITS (COORD_BITS)
  ) u_sort (
    .raw_x  (s1_x),
    .raw_y  (s1_y),
    .slot_x (slot_x),
    .slot_y (slot_y)
  );

  // hit window
  logic stable;

  qcts_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .hit       (s1_detect),
    .update    (move),
    .threshold (pass_threshold),
    .stable    (stable)
  );

  // ema state and lanes
  logic                smoothed_valid;
  logic [FIX_BITS-1:0] smoothed  [NUM_COORDS];
  logic [FIX_BITS-1:0] new_fix   [NUM_COORDS];
  logic [FIX_BITS-1:0] blend_fix [NUM_COORDS];

  for (genvar q = 0; q < NUM_CORNERS; q++) begin : g_fix
    assign new_fix[2*q]   = {slot_x[q], {FRAC_BITS{1'b0}}};
    assign new_fix[2*q+1] = {slot_y[q], {FRAC_BITS{1'b0}}};
  end

  for (genvar c = 0; c < NUM_COORDS; c++) begin : g_lane
    qcts_ema_lane #(
      .FIX_BITS (FIX_BITS)
    ) u_lane (
      .alpha     (alpha_sat),
      .first     (!smoothed_valid),
      .new_val   (new_fix[c]),
      .held_val  (smoothed[c]),
      .blend_val (blend_fix[c])
    );
  end

  logic emit;
  assign emit = s1_detect || (stable && smoothed_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_valid <= 1'b0;
    end else if (move && s1_detect) begin
      smoothed_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && s1_detect) begin
      for (int c = 0; c < NUM_COORDS; c++) begin
        smoothed[c] <= blend_fix[c];
      end
    end
  end

  // result register
  logic                out_status;
  logic [FIX_BITS-1:0] out_coord [NUM_COORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_status <= emit;
      for (int c = 0; c < NUM_COORDS; c++) begin
        if (!emit) begin
          out_coord[c] <= '0;
        end else if (s1_detect) begin
          out_coord[c] <= blend_fix[c];
        end else begin
          out_coord[c] <= smoothed[c];
        end
      end
    end
  end

  // center from the registered corners; a lost result has all corners zero
  logic [CSUM_BITS-1:0] sum_cx;
  logic [CSUM_BITS-1:0] sum_cy;

  assign sum_cx = CSUM_BITS'(out_coord[0]) + CSUM_BITS'(out_coord[2])
                + CSUM_BITS'(out_coord[4]) + CSUM_BITS'(out_coord[6]);
  assign sum_cy = CSUM_BITS'(out_coord[1]) + CSUM_BITS'(out_coord[3])
                + CSUM_BITS'(out_coord[5]) + CSUM_BITS'(out_coord[7]);

  assign track_status   = out_status;
  assign top_left_x     = out_coord[0];
  assign top_left_y     = out_coord[1];
  assign top_right_x    = out_coord[2];
  assign top_right_y    = out_coord[3];
  assign bottom_right_x = out_coord[4];
  assign bottom_right_y = out_coord[5];
  assign bottom_left_x  = out_coord[6];
  assign bottom_left_y  = out_coord[7];
  assign center_x       = sum_cx[CSUM_BITS-1:2];
  assign center_y       = sum_cy[CSUM_BITS-1:2];

  a_lost_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !track_status |-> top_left_x == '0 && bottom_right_y == '0 && center_x == '0)
    else $error("lost result carries nonzero corners");

  a_hit_tracks: assert property (@(posedge clk) disable iff (rst)
    move && s1_detect |=> out_valid && track_status && smoothed_valid)
    else $error("detected frame did not produce a tracking result");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(smoothed_valid))
    else $error("smoothed corners lost without reset");

endmodule

`default_nettype wire
